@@ hw/rtl/eomc_pkg.sv @@
// Shared types, constants and helpers of the edge odometry mean block.
// Used by every module under hw/rtl; depends on nothing.
package eomc_pkg;

	// Width of the shared add/subtract/compare unit
	localparam int AW = 104;

	// Operation codes of the shared unit
	localparam logic ALU_ADD = 1'b0;
	localparam logic ALU_SUB = 1'b1;

	// Input modes
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SET = 2'd1;

	// Register map: bit 2 of the byte address selects the register
	localparam logic REG_VARIANCE = 1'b0;
	localparam logic [31:0] K_RESET = 32'd65536;

	localparam logic [15:0] MAX_OBSERVATIONS = 16'd65535;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [21:0] T_CAP = 22'd1572864;

	typedef struct packed {
		logic op;
		logic [AW-1:0] a;
		logic [AW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [AW-1:0] res;
		logic ge;
	} alu_rsp_t;

	// Negate with saturation of the most negative value
	function automatic logic [31:0] neg_sat(input logic [31:0] v);
		return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : (~v + 32'd1);
	endfunction

	// Magnitude of a signed 32-bit value as unsigned 32 bits
	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

@@ hw/rtl/eomc_alu.sv @@
// Shared wide add/subtract unit with unsigned compare flag.
// Depends on eomc_pkg.
module eomc_alu import eomc_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [AW:0] diff;

	// Subtract with borrow out; no borrow means a >= b
	assign diff = {1'b0, req.a} - {1'b0, req.b};
	assign rsp.ge = ~diff[AW];
	assign rsp.res = (req.op == ALU_SUB) ? diff[AW-1:0] : (req.a + req.b);

endmodule

@@ hw/rtl/eomc_mul.sv @@
// Shared 32x32 unsigned multiplier with registered product.
// Depends on eomc_pkg only for the common import style.
module eomc_mul import eomc_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	// Register the product, ready in the cycle after the operands
	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule

@@ hw/rtl/eomc_apb.sv @@
// APB register port holding the variance-per-meter setting.
// Depends on eomc_pkg for the register map and reset value.
module eomc_apb import eomc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [31:0] variance
);

	logic [31:0] var_q;
	logic        sel_var;

	assign sel_var = (paddr[2] == REG_VARIANCE);

	// Write the register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_q <= K_RESET;
		end else if (psel && penable && pwrite && sel_var) begin
			var_q <= pwdata;
		end
	end

	assign prdata = sel_var ? var_q : 32'd0;
	assign pready = 1'b1;
	assign variance = var_q;

endmodule

@@ hw/rtl/eomc_core.sv @@
// Sequencer and datapath: square roots, match division, exp series and mean folds,
// all run through one shared multiplier and one shared add/subtract unit.
// Depends on eomc_pkg, eomc_alu and eomc_mul.
module eomc_core import eomc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] variance,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic        from_side,
	input  logic [31:0] delta_x,
	input  logic [31:0] delta_y,
	input  logic [31:0] turn_yaw,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] confidence,
	output logic [31:0] avg_x,
	output logic [31:0] avg_y,
	output logic [31:0] avg_yaw,
	output logic [15:0] count_out
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_M1   = 5'd1;
	localparam logic [4:0] S_M2   = 5'd2;
	localparam logic [4:0] S_M3   = 5'd3;
	localparam logic [4:0] S_SQRT = 5'd4;
	localparam logic [4:0] S_SQE  = 5'd5;
	localparam logic [4:0] S_M4   = 5'd6;
	localparam logic [4:0] S_M5   = 5'd7;
	localparam logic [4:0] S_M6   = 5'd8;
	localparam logic [4:0] S_DIFF = 5'd9;
	localparam logic [4:0] S_KR   = 5'd10;
	localparam logic [4:0] S_D2   = 5'd11;
	localparam logic [4:0] S_D3   = 5'd12;
	localparam logic [4:0] S_D4   = 5'd13;
	localparam logic [4:0] S_D5   = 5'd14;
	localparam logic [4:0] S_D6   = 5'd15;
	localparam logic [4:0] S_DIV  = 5'd16;
	localparam logic [4:0] S_TQ   = 5'd17;
	localparam logic [4:0] S_E1   = 5'd18;
	localparam logic [4:0] S_E2   = 5'd19;
	localparam logic [4:0] S_E3   = 5'd20;
	localparam logic [4:0] S_CL   = 5'd21;
	localparam logic [4:0] S_SQ1  = 5'd22;
	localparam logic [4:0] S_SQ2  = 5'd23;
	localparam logic [4:0] S_CONF = 5'd24;
	localparam logic [4:0] S_F1   = 5'd25;
	localparam logic [4:0] S_F2   = 5'd26;
	localparam logic [4:0] S_F3   = 5'd27;
	localparam logic [4:0] S_F4   = 5'd28;
	localparam logic [4:0] S_F5   = 5'd29;
	localparam logic [4:0] S_DONE = 5'd30;

	// Where the divider loop returns
	localparam logic [1:0] R_TDIV = 2'd0;
	localparam logic [1:0] R_EXP  = 2'd1;
	localparam logic [1:0] R_FOLD = 2'd2;

	localparam logic [3:0] LAST_TERM = 4'd12;
	localparam logic [1:0] FSEL_YAW = 2'd2;

	logic [4:0]  st_q;
	logic [5:0]  cnt_q;
	logic [1:0]  ret_q;
	logic        sel_q;
	logic        side_q;
	logic        neg_q;
	logic [1:0]  fsel_q;
	logic [3:0]  ix_q;
	logic [31:0] ox_q, oy_q, oyaw_q;
	logic [31:0] mean_x_q, mean_y_q, mean_yaw_q;
	logic [15:0] obs_q;
	logic [63:0] acc_q, va_q, rt_q, bit_q, kr_q, d2_q;
	logic [31:0] rec_q, got_q, diff_q, term_q, f_q;
	logic [32:0] s_q;
	logic [AW-1:0] rem_q, dsh_q, den_q;
	logic [32:0] quo_q;
	logic [16:0] conf_q;

	logic        out_valid_q;
	logic [16:0] o_conf_q;
	logic [31:0] o_x_q, o_y_q, o_yaw_q;
	logic [15:0] o_cnt_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;

	logic [16:0] n1;
	logic [31:0] mean_sel, obs_sel, diff_w, f_w, fold_w;
	logic        out_load;

	eomc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	eomc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign n1 = {1'b0, obs_q} + 17'd1;
	assign f_w = {quo_q[20:0], 11'b0};
	assign diff_w = alu_rsp.ge ? alu_rsp.res[31:0] : (~alu_rsp.res[31:0] + 32'd1);
	assign fold_w = neg_q ? alu_rsp.res[31:0] : quo_q[31:0];
	assign out_load = (st_q == S_DONE) && (!out_valid_q || out_ready);

	// Pick the mean and observation being folded
	always_comb begin
		case (fsel_q)
			2'd0: begin
				mean_sel = mean_x_q;
				obs_sel = ox_q;
			end
			2'd1: begin
				mean_sel = mean_y_q;
				obs_sel = oy_q;
			end
			default: begin
				mean_sel = mean_yaw_q;
				obs_sel = oyaw_q;
			end
		endcase
	end

	// Drive the shared multiplier
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (st_q)
			S_M1: begin
				mul_a = mag32(mean_x_q);
				mul_b = mag32(mean_x_q);
			end
			S_M2: begin
				mul_a = mag32(mean_y_q);
				mul_b = mag32(mean_y_q);
			end
			S_M4: begin
				mul_a = mag32(ox_q);
				mul_b = mag32(ox_q);
			end
			S_M5: begin
				mul_a = mag32(oy_q);
				mul_b = mag32(oy_q);
			end
			S_DIFF: begin
				mul_a = variance;
				mul_b = rec_q;
			end
			S_KR: begin
				mul_a = diff_q;
				mul_b = diff_q;
			end
			S_D2: begin
				mul_a = kr_q[31:0];
				mul_b = 32'(n1);
			end
			S_D3: begin
				mul_a = kr_q[63:32];
				mul_b = 32'(n1);
			end
			S_D4: begin
				mul_a = d2_q[31:0];
				mul_b = 32'(obs_q);
			end
			S_D5: begin
				mul_a = d2_q[63:32];
				mul_b = 32'(obs_q);
			end
			S_E1: begin
				mul_a = term_q;
				mul_b = f_q;
			end
			S_SQ1: begin
				mul_a = s_q[31:0];
				mul_b = s_q[31:0];
			end
			S_F1: begin
				mul_a = mag32(mean_sel);
				mul_b = 32'(obs_q);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// Drive the shared add/subtract unit
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a = '0;
		alu_req.b = '0;
		case (st_q)
			S_M3, S_M6: begin
				alu_req.a = AW'(acc_q);
				alu_req.b = AW'(prod);
			end
			S_SQRT: begin
				alu_req.op = ALU_SUB;
				alu_req.a = AW'(va_q);
				alu_req.b = AW'(rt_q | bit_q);
			end
			S_DIFF: begin
				alu_req.op = ALU_SUB;
				alu_req.a = AW'(rec_q);
				alu_req.b = AW'(got_q);
			end
			S_D4: begin
				alu_req.a = den_q;
				alu_req.b = {8'b0, prod, 32'b0};
			end
			S_D6: begin
				alu_req.a = rem_q;
				alu_req.b = {8'b0, prod, 32'b0};
			end
			S_DIV: begin
				alu_req.op = ALU_SUB;
				alu_req.a = rem_q;
				alu_req.b = dsh_q;
			end
			S_TQ: begin
				alu_req.op = ALU_SUB;
				alu_req.a = AW'(33'h1_0000_0000);
				alu_req.b = AW'(f_w);
			end
			S_E3: begin
				alu_req.op = ix_q[0] ? ALU_SUB : ALU_ADD;
				alu_req.a = AW'(s_q);
				alu_req.b = AW'(quo_q[31:0]);
			end
			S_SQ2: begin
				alu_req.a = AW'(prod);
				alu_req.b = AW'(32'h8000_0000);
			end
			S_CONF: begin
				alu_req.a = AW'(s_q);
				alu_req.b = AW'(17'd32768);
			end
			S_F2: begin
				alu_req.op = mean_sel[31] ? ALU_SUB : ALU_ADD;
				alu_req.a = {{(AW-32){obs_sel[31]}}, obs_sel};
				alu_req.b = AW'(prod);
			end
			S_F3: begin
				alu_req.op = ALU_SUB;
				alu_req.b = rem_q;
			end
			S_F4: begin
				alu_req.a = rem_q;
				alu_req.b = AW'(n1[16:1]);
			end
			S_F5: begin
				alu_req.op = ALU_SUB;
				alu_req.b = AW'(quo_q);
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	// Sequence one item through the shared units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			ret_q <= R_TDIV;
			sel_q <= 1'b0;
			side_q <= 1'b0;
			neg_q <= 1'b0;
			fsel_q <= '0;
			ix_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			oyaw_q <= '0;
			mean_x_q <= '0;
			mean_y_q <= '0;
			mean_yaw_q <= '0;
			obs_q <= '0;
			acc_q <= '0;
			va_q <= '0;
			rt_q <= '0;
			bit_q <= '0;
			kr_q <= '0;
			d2_q <= '0;
			rec_q <= '0;
			got_q <= '0;
			diff_q <= '0;
			term_q <= '0;
			f_q <= '0;
			s_q <= '0;
			rem_q <= '0;
			dsh_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			conf_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						side_q <= from_side;
						fsel_q <= '0;
						oyaw_q <= turn_yaw;
						if (mode == MODE_ADD && from_side) begin
							ox_q <= neg_sat(delta_x);
							oy_q <= neg_sat(delta_y);
						end else begin
							ox_q <= delta_x;
							oy_q <= delta_y;
						end
						case (mode)
							MODE_ADD: begin
								if (obs_q == 16'd0) begin
									conf_q <= ONE_Q16;
									st_q <= S_F1;
								end else begin
									st_q <= S_M1;
								end
							end
							MODE_SET: begin
								mean_x_q <= delta_x;
								mean_y_q <= delta_y;
								mean_yaw_q <= turn_yaw;
								obs_q <= 16'd1;
								conf_q <= '0;
								st_q <= S_DONE;
							end
							default: begin
								conf_q <= '0;
								st_q <= S_DONE;
							end
						endcase
					end
				end
				S_M1: st_q <= S_M2;
				S_M2: begin
					acc_q <= prod;
					st_q <= S_M3;
				end
				S_M3, S_M6: begin
					va_q <= alu_rsp.res[63:0];
					rt_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
					cnt_q <= 6'd31;
					sel_q <= (st_q == S_M6);
					st_q <= S_SQRT;
				end
				// One root digit per cycle
				S_SQRT: begin
					if (alu_rsp.ge) begin
						va_q <= alu_rsp.res[63:0];
						rt_q <= (rt_q >> 1) | bit_q;
					end else begin
						rt_q <= rt_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == 6'd0) begin
						st_q <= S_SQE;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_SQE: begin
					if (!sel_q) begin
						rec_q <= rt_q[31:0];
						st_q <= S_M4;
					end else begin
						got_q <= rt_q[31:0];
						st_q <= S_DIFF;
					end
				end
				S_M4: st_q <= S_M5;
				S_M5: begin
					acc_q <= prod;
					st_q <= S_M6;
				end
				S_DIFF: begin
					if (diff_w == 32'd0) begin
						conf_q <= ONE_Q16;
						st_q <= S_F1;
					end else begin
						diff_q <= diff_w;
						st_q <= S_KR;
					end
				end
				S_KR: begin
					kr_q <= prod;
					if (prod == 64'd0) begin
						conf_q <= '0;
						st_q <= S_F1;
					end else begin
						st_q <= S_D2;
					end
				end
				S_D2: begin
					d2_q <= prod;
					st_q <= S_D3;
				end
				S_D3: begin
					den_q <= AW'(prod);
					st_q <= S_D4;
				end
				S_D4: begin
					den_q <= alu_rsp.res;
					st_q <= S_D5;
				end
				S_D5: begin
					rem_q <= AW'(prod);
					st_q <= S_D6;
				end
				// Scale numerator by 2^16, align divisor to the top quotient bit
				S_D6: begin
					rem_q <= {alu_rsp.res[AW-17:0], 16'b0};
					dsh_q <= {den_q[AW-22:0], 21'b0};
					quo_q <= '0;
					cnt_q <= 6'd21;
					ret_q <= R_TDIV;
					st_q <= S_DIV;
				end
				// One quotient bit per cycle
				S_DIV: begin
					if (alu_rsp.ge) begin
						rem_q <= alu_rsp.res;
					end
					quo_q <= {quo_q[31:0], alu_rsp.ge};
					dsh_q <= dsh_q >> 1;
					if (cnt_q == 6'd0) begin
						case (ret_q)
							R_TDIV: st_q <= S_TQ;
							R_EXP: st_q <= S_E3;
							default: st_q <= S_F5;
						endcase
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_TQ: begin
					fsel_q <= '0;
					if (quo_q[21:0] >= T_CAP) begin
						conf_q <= '0;
						st_q <= S_F1;
					end else if (quo_q[21:0] == 22'd0) begin
						conf_q <= ONE_Q16;
						st_q <= S_F1;
					end else begin
						f_q <= f_w;
						term_q <= f_w;
						s_q <= alu_rsp.res[32:0];
						ix_q <= 4'd2;
						st_q <= S_E1;
					end
				end
				S_E1: st_q <= S_E2;
				// Divide the scaled term by its index
				S_E2: begin
					rem_q <= AW'(prod[63:32]);
					dsh_q <= {{(AW-35){1'b0}}, ix_q, 31'b0};
					quo_q <= '0;
					cnt_q <= 6'd31;
					ret_q <= R_EXP;
					st_q <= S_DIV;
				end
				S_E3: begin
					term_q <= quo_q[31:0];
					s_q <= alu_rsp.res[32:0];
					if (ix_q == LAST_TERM) begin
						st_q <= S_CL;
					end else begin
						ix_q <= ix_q + 4'd1;
						st_q <= S_E1;
					end
				end
				S_CL: begin
					if (s_q[32]) begin
						s_q <= 33'h0_FFFF_FFFF;
					end
					cnt_q <= 6'd3;
					st_q <= S_SQ1;
				end
				S_SQ1: st_q <= S_SQ2;
				S_SQ2: begin
					s_q <= {1'b0, alu_rsp.res[63:32]};
					if (cnt_q == 6'd0) begin
						st_q <= S_CONF;
					end else begin
						cnt_q <= cnt_q - 6'd1;
						st_q <= S_SQ1;
					end
				end
				S_CONF: begin
					conf_q <= alu_rsp.res[32:16];
					fsel_q <= '0;
					st_q <= S_F1;
				end
				S_F1: st_q <= S_F2;
				S_F2: begin
					rem_q <= alu_rsp.res;
					st_q <= S_F3;
				end
				S_F3: begin
					neg_q <= rem_q[AW-1];
					if (rem_q[AW-1]) begin
						rem_q <= alu_rsp.res;
					end
					st_q <= S_F4;
				end
				// Add half the divisor, then divide by n + 1
				S_F4: begin
					rem_q <= alu_rsp.res;
					dsh_q <= {{(AW-49){1'b0}}, n1, 32'b0};
					quo_q <= '0;
					cnt_q <= 6'd32;
					ret_q <= R_FOLD;
					st_q <= S_DIV;
				end
				S_F5: begin
					case (fsel_q)
						2'd0: mean_x_q <= fold_w;
						2'd1: mean_y_q <= fold_w;
						default: mean_yaw_q <= fold_w;
					endcase
					if (fsel_q == FSEL_YAW) begin
						if (obs_q < MAX_OBSERVATIONS) begin
							obs_q <= obs_q + 16'd1;
						end
						st_q <= S_DONE;
					end else begin
						fsel_q <= fsel_q + 2'd1;
						st_q <= S_F1;
					end
				end
				S_DONE: begin
					if (out_load) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Hold the result word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			o_conf_q <= '0;
			o_x_q <= '0;
			o_y_q <= '0;
			o_yaw_q <= '0;
			o_cnt_q <= '0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			o_conf_q <= conf_q;
			o_x_q <= side_q ? neg_sat(mean_x_q) : mean_x_q;
			o_y_q <= side_q ? neg_sat(mean_y_q) : mean_y_q;
			o_yaw_q <= mean_yaw_q;
			o_cnt_q <= obs_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign confidence = o_conf_q;
	assign avg_x = o_x_q;
	assign avg_y = o_y_q;
	assign avg_yaw = o_yaw_q;
	assign count_out = o_cnt_q;

endmodule

@@ hw/rtl/edge_odometry_mean_with_confidence.sv @@
// Running odometry mean of one map edge with a match confidence per observation.
// Top level; depends on eomc_pkg, eomc_apb and eomc_core.
//
// Input words (mode, from_side, delta_x, delta_y, turn_yaw) enter on in_valid/in_ready;
// one result word (confidence, avg_x, avg_y, avg_yaw, count_out) leaves on
// out_valid/out_ready for each input word. The variance register sits at APB
// byte address 0; pready is always high.
// One word is worked at a time; in_ready is high only while the sequencer is idle.
// Set and read go straight to the result. Add for the first observation runs three
// mean folds, each a multiply and a 33-step divide; otherwise it runs two 32-step
// square roots, a 22-step division, eleven series terms each with a 32-step
// divide, four squarings and the folds. Equal lengths, a zero recorded length or a
// large mismatch skip the series. The single shared add/subtract unit works one
// bit per cycle. The next word is taken in the cycle after the result is loaded.
// The result sits in an output register: a new input word is taken while it
// waits, and the sequencer holds at its last step if the receiver still stalls
// when the next result is ready.
// Reset clears the means and count to zero and the variance register to 1.0.
module edge_odometry_mean_with_confidence import eomc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic               from_side,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] turn_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        confidence,
	output logic signed [31:0] avg_x,
	output logic signed [31:0] avg_y,
	output logic signed [31:0] avg_yaw,
	output logic [15:0]        count_out
);

	logic [31:0] variance;

	eomc_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.variance (variance)
	);

	eomc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.variance   (variance),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.from_side  (from_side),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.turn_yaw   (turn_yaw),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.confidence (confidence),
		.avg_x      (avg_x),
		.avg_y      (avg_y),
		.avg_yaw    (avg_yaw),
		.count_out  (count_out)
	);

endmodule

@@ hw/rtl/eomc_checker.sv @@
// Port-level checks of the edge odometry mean block, bound to its top level.
// Depends on eomc_pkg and edge_odometry_mean_with_confidence.
module eomc_checker import eomc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [16:0]        confidence,
	input logic signed [31:0] avg_x,
	input logic [15:0]        count_out
);

	// Stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(confidence) && $stable(avg_x))
		else $error("result word dropped or changed under stall");

	// Busy after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// Confidence never above 1.0
	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> confidence <= ONE_Q16)
		else $error("confidence above one");

	// Empty edge reports no confidence
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_out == 16'd0 |-> confidence == 17'd0)
		else $error("confidence on an empty edge");

endmodule

bind edge_odometry_mean_with_confidence eomc_checker u_eomc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.confidence (confidence),
	.avg_x      (avg_x),
	.count_out  (count_out)
);

@@ test/edge_odometry_mean_with_confidence_test.sv @@
// Testbench of the edge odometry mean block: directed and random words, own predictor.
// Depends on eomc_pkg and edge_odometry_mean_with_confidence.
module edge_odometry_mean_with_confidence_test;
	import eomc_pkg::*;

	typedef struct packed {
		logic [1:0] mode;
		logic side;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dyaw;
	} odo_word_t;

	typedef struct packed {
		logic [16:0] conf;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] ayaw;
		logic [15:0] cnt;
	} mean_word_t;

	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_RD3 = 2'd3;
	localparam logic [2:0] ADDR_VARIANCE = 3'd0;
	localparam int LIMIT = 3000000;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [1:0] mode = '0;
	logic from_side = 0;
	logic signed [31:0] delta_x = '0, delta_y = '0, turn_yaw = '0;
	logic [16:0] confidence;
	logic signed [31:0] avg_x, avg_y, avg_yaw;
	logic [15:0] count_out;

	edge_odometry_mean_with_confidence dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// predictor state
	logic [31:0] k_var = K_RESET;
	logic signed [31:0] m_x = 0, m_y = 0, m_yaw = 0;
	logic [15:0] n_obs = 0;

	odo_word_t pending_words[$];
	mean_word_t expected_means[$];
	int errors = 0, cycles = 0, accepted_in = 0, accepted_out = 0;
	bit long_hold = 0;

	function automatic logic [31:0] negs(logic [31:0] v);
		return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : -v;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] absv(logic signed [31:0] v);
		return v < 0 ? 64'(-64'(v)) : 64'(v);
	endfunction

	function automatic logic [16:0] exp_half(logic [31:0] tq);
		logic [63:0] f, term, s;
		logic [127:0] p;
		f = 64'(tq) << 11;
		term = 64'd1 << 32;
		s = term;
		for (int i = 1; i <= 12; i++) begin
			p = 128'(term) * 128'(f);
			term = p[95:32] / i;
			if (i % 2) s -= term; else s += term;
		end
		if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
		for (int i = 0; i < 4; i++) s = (s * s + 64'h8000_0000) >> 32;
		return 17'((s + 64'd32768) >> 16);
	endfunction

	function automatic logic [16:0] match_conf(logic signed [31:0] ox,
			logic signed [31:0] oy);
		logic [63:0] rec, got, diff, kr;
		logic [191:0] num, den;
		logic [31:0] q;
		if (n_obs == 0) return ONE_Q16;
		rec = root64(absv(m_x) * absv(m_x) + absv(m_y) * absv(m_y));
		got = root64(absv(ox) * absv(ox) + absv(oy) * absv(oy));
		diff = rec > got ? rec - got : got - rec;
		if (diff == 0) return ONE_Q16;
		kr = 64'(k_var) * rec;
		if (kr == 0) return 0;
		num = (192'(diff * diff) * 192'(n_obs)) << 16;
		num = num & {64'd0, {128{1'b1}}};
		den = 192'(kr) * 192'(32'(n_obs) + 1);
		q = 0;
		for (int b = 21; b >= 0; b--)
			if (num >= (den << b)) begin
				num -= den << b;
				q[b] = 1;
			end
		if (q >= 32'(T_CAP)) return 0;
		if (q == 0) return ONE_Q16;
		return exp_half(q);
	endfunction

	function automatic logic [31:0] fold(logic signed [31:0] mean,
			logic signed [31:0] obs, logic [15:0] n);
		logic signed [63:0] tot;
		logic [63:0] d, m;
		tot = 64'(mean) * $signed({48'd0, n}) + 64'(obs);
		d = 64'(n) + 1;
		m = ((tot < 0 ? 64'(-tot) : 64'(tot)) + d / 2) / d;
		return tot < 0 ? 32'(-m) : 32'(m);
	endfunction

	// Work out the result word of one accepted input word
	function automatic mean_word_t predict_means(odo_word_t w);
		mean_word_t r;
		logic signed [31:0] dx, dy;
		r.conf = 0;
		dx = w.dx;
		dy = w.dy;
		if (w.mode == MODE_ADD) begin
			if (w.side) begin
				dx = negs(dx);
				dy = negs(dy);
			end
			r.conf = match_conf(dx, dy);
			m_x = fold(m_x, dx, n_obs);
			m_y = fold(m_y, dy, n_obs);
			m_yaw = fold(m_yaw, w.dyaw, n_obs);
			if (n_obs < MAX_OBSERVATIONS) n_obs++;
		end else if (w.mode == MODE_SET) begin
			m_x = w.dx;
			m_y = w.dy;
			m_yaw = w.dyaw;
			n_obs = 1;
		end
		r.ax = w.side ? negs(m_x) : m_x;
		r.ay = w.side ? negs(m_y) : m_y;
		r.ayaw = m_yaw;
		r.cnt = n_obs;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, accepted_out);
		errors++;
	endtask

	// Driver: bursts with random gaps; hold valid and payload until accepted
	int gap = 0, burst = 0;
	always @(posedge clk) begin
		cycles++;
		if (in_valid && in_ready) accepted_in++;
		if (in_valid && !in_ready) begin
			// hold
		end else if (pending_words.size() > 0 && gap == 0) begin
			odo_word_t w;
			w = pending_words.pop_front();
			in_valid <= 1;
			{mode, from_side, delta_x, delta_y, turn_yaw} <= w;
			expected_means.push_back(predict_means(w));
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			end else burst--;
		end else begin
			in_valid <= 0;
			if (gap > 0) gap--;
		end
	end

	// Receiver stall pattern, with one long hold-off
	int hold_cnt = 0;
	always @(posedge clk) begin
		if (long_hold) out_ready <= 0;
		else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if ($urandom_range(0, 9) == 0) hold_cnt = $urandom_range(1, 60);
		end
	end

	// Monitor: compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			mean_word_t e;
			accepted_out++;
			if (expected_means.size() == 0) begin
				report_mismatch("unexpected result word", 32'(confidence), 32'd0);
			end else begin
				e = expected_means.pop_front();
				if (confidence !== e.conf) report_mismatch("confidence", confidence, e.conf);
				if (avg_x !== e.ax) report_mismatch("avg_x", avg_x, e.ax);
				if (avg_y !== e.ay) report_mismatch("avg_y", avg_y, e.ay);
				if (avg_yaw !== e.ayaw) report_mismatch("avg_yaw", avg_yaw, e.ayaw);
				if (count_out !== e.cnt) report_mismatch("count_out", count_out, e.cnt);
			end
		end
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_variance(logic [31:0] v);
		psel <= 1;
		pwrite <= 1;
		paddr <= ADDR_VARIANCE;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		k_var = v;
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_means.size() > 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_len();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return 32'($signed($urandom_range(0, 20)) - 10);
			default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
		endcase
	endfunction

	task automatic push(logic [1:0] md, logic sd, logic [31:0] x, logic [31:0] y,
			logic [31:0] yw);
		pending_words.push_back({md, sd, x, y, yw});
	endtask

	initial begin
		logic [31:0] kv;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: first observation, equal lengths, extremes, set, read, mode 3
		push(MODE_READ, 0, 0, 0, 0);
		push(MODE_ADD, 0, 32'sd3 << 16, 32'sd4 << 16, 32'sd1 << 16);
		push(MODE_ADD, 1, -(32'sd4 << 16), 32'sd3 << 16, 0);
		push(MODE_ADD, 0, 32'sd30 << 16, 0, 32'h8000_0000);
		push(MODE_ADD, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		push(MODE_ADD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		push(MODE_READ, 1, 0, 0, 0);
		push(MODE_RD3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push(MODE_SET, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		push(MODE_READ, 1, 0, 0, 0);
		push(MODE_SET, 0, 0, 0, 0);
		push(MODE_ADD, 0, 32'sd2 << 16, 0, 0);
		push(MODE_ADD, 0, 32'sd1 << 16, 32'sd1, 32'sd5);
		push(MODE_ADD, 1, 32'sd1 << 16, 32'sd1, 32'sd5);
		drain();
		// zero variance register, then the largest one
		write_variance(32'd0);
		push(MODE_ADD, 0, 32'sd5 << 16, 0, 0);
		push(MODE_ADD, 0, 32'sd5 << 16, 0, 0);
		drain();
		write_variance(32'hFFFF_FFFF);
		push(MODE_ADD, 0, 32'sd9 << 16, 0, 0);
		push(MODE_ADD, 0, 32'sd1 << 16, 32'sd1 << 16, 0);
		drain();
		// long receiver hold-off while the sender keeps offering
		long_hold = 1;
		for (int i = 0; i < 8; i++)
			push(MODE_ADD, 1'($urandom), rand_len(), rand_len(), $urandom);
		repeat (3000) @(posedge clk);
		long_hold = 0;
		drain();
		// random phases with different variance settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: kv = 32'd1;
				1: kv = 32'd65536;
				2: kv = 32'hFFFF_FFFF;
				default: kv = $urandom_range(1, 32'h0010_0000);
			endcase
			write_variance(kv);
			for (int i = 0; i < 180; i++) begin
				int sel;
				sel = $urandom_range(0, 19);
				if (sel < 15)
					push(MODE_ADD, 1'($urandom), rand_len(), rand_len(), $urandom);
				else if (sel < 17)
					push(MODE_SET, 1'($urandom), rand_len(), rand_len(), $urandom);
				else
					push(2'($urandom_range(2, 3)), 1'($urandom), $urandom, $urandom,
						$urandom);
			end
			drain();
		end
		$display("Covered %0d input words, %0d result words, variance extremes 0..max",
			accepted_in, accepted_out);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

@@ files.f @@
hw/rtl/eomc_pkg.sv
hw/rtl/eomc_alu.sv
hw/rtl/eomc_mul.sv
hw/rtl/eomc_apb.sv
hw/rtl/eomc_core.sv
hw/rtl/edge_odometry_mean_with_confidence.sv
hw/rtl/eomc_checker.sv
test/edge_odometry_mean_with_confidence_test.sv
